// ----- design/bb_pkg.sv -----
package bb_pkg;

  // Channel and item geometry
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int CELLS  = 9;
  localparam int SUM_W  = 12;  // 9 * 255 = 2295

  // Configuration register widths
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_CHAN_W   = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  // Frame height limits
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int H_W        = 13;

  // Reset values of the registers
  localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [CFG_CHAN_W-1:0]   RST_CHAN   = 3'd3;

  // Divide by nine: multiply by ceil(2^16 / 9), exact for sums up to 2295
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_index_t;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] in_chan0;
    logic [CH_W-1:0] in_chan1;
    logic [CH_W-1:0] in_chan2;
    logic [CH_W-1:0] in_chan3;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_chan0;
    logic [CH_W-1:0] out_chan1;
    logic [CH_W-1:0] out_chan2;
    logic [CH_W-1:0] out_chan3;
    logic            frame_last;
  } out_item_t;

  // Truncated mean of a nine-cell sum
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] p;
    p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP9);
    return p[RECIP_SHIFT +: CH_W];
  endfunction

endpackage

// ----- design/bb_line_buf.sv -----
// Two line stores sharing one write address, each with its own read port.
// Read data is registered; a write landing on the address being read in the
// same cycle is forwarded.
module bb_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PXW   = 32
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [AW-1:0]  up_rd_addr,
  input  logic [AW-1:0]  mid_rd_addr,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [PXW-1:0] up_wdata,
  input  logic [PXW-1:0] mid_wdata,
  output logic [PXW-1:0] up_rd_data,
  output logic [PXW-1:0] mid_rd_data
);

  logic [PXW-1:0] upper_mem  [DEPTH];
  logic [PXW-1:0] middle_mem [DEPTH];
  logic [PXW-1:0] up_rd_r;
  logic [PXW-1:0] mid_rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= up_wdata;
      middle_mem[wr_addr] <= mid_wdata;
    end
  end

  // Registered reads with same-cycle write forwarding
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rd_r  <= (wr_en && wr_addr == up_rd_addr) ? up_wdata : upper_mem[up_rd_addr];
      mid_rd_r <= (wr_en && wr_addr == mid_rd_addr) ? mid_wdata : middle_mem[mid_rd_addr];
    end
  end

  assign up_rd_data  = up_rd_r;
  assign mid_rd_data = mid_rd_r;

endmodule

// ----- design/box_blur_3x3.sv -----
// 3x3 box filter over a raster-order pixel stream of up to four 8-bit
// channels. Interior pixels become the per-channel truncated mean of their
// 3x3 neighborhood; pixels on the outer ring of the frame pass through.
// One item (pixel or drain) is taken every clock while in_stall is low;
// results are registered on out_*, and out_stall backs up through a single
// working stage into in_stall. Results lag the pixels by image_width+1
// positions, so after the frame's last pixel the user sends drain items
// (kind = 1), each giving one pending pixel, until frame_last. Pixel items
// sent while pixels are pending, and drain items with nothing pending, are
// taken and dropped. Two line stores of MAX_WIDTH pixels each, read once per
// item through registered ports, set the one-per-clock rate; they need no
// clearing after reset. Registers are to be written by the user only while
// the block is idle; it does not enforce this. Any write restarts the frame.
module box_blur_3x3 import bb_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel/drain items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int EW  = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
  localparam int PXW = CH_W * MAX_CHANNELS;

  // Configuration registers
  logic [CFG_WIDTH_W-1:0]  image_width_r, image_width_nxt;
  logic [CFG_HEIGHT_W-1:0] image_height_r, image_height_nxt;
  logic [CFG_CHAN_W-1:0]   channel_count_r, channel_count_nxt;
  logic                    cfg_hit;

  // Frame position
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PW-1:0]    pending_r, pending_nxt;

  // Effective (clamped) settings
  logic [EW-1:0]         width_ext;
  logic [WW-1:0]         eff_w;
  logic [H_W-1:0]        eff_h;
  logic [CFG_CHAN_W-1:0] eff_ch;

  // Accept-side decode
  logic             in_acc;
  logic             is_drain;
  logic             drain_act;
  logic             pix_act;
  logic             produce;
  logic             interior;
  logic [ROW_W-1:0] orow;
  logic [WW-1:0]    ocol;
  logic             sel_upper;
  logic [AW-1:0]    up_rd_addr;
  logic [AW-1:0]    mid_rd_addr;
  logic [PXW-1:0]   cur_px;
  logic [CH_W-1:0]  in_ch [NUM_CH];

  // Working stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_pix_r;
  logic             s1_emit_r;
  logic             s1_interior_r;
  logic             s1_sel_upper_r;
  logic             s1_last_r;
  logic [AW-1:0]    s1_col_r;
  logic [PXW-1:0]   s1_cur_r;
  logic             s1_go;
  logic             out_free;
  logic [PXW-1:0]   up_rd;
  logic [PXW-1:0]   mid_rd;
  logic [PXW-1:0]   wc_r [6];
  logic [PXW-1:0]   cells [CELLS];
  logic [PXW-1:0]   mean_px;
  logic [PXW-1:0]   res_px;
  logic [CH_W-1:0]  och [NUM_CH];

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      out_load;

  // --------------------------------------------------------------------
  // Clamp register values
  assign width_ext = EW'(image_width_r);
  always_comb begin
    if (width_ext == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_ext);
    end
    if (image_height_r == '0) begin
      eff_h = H_W'(1);
    end else if (image_height_r > H_W'(MAX_HEIGHT)) begin
      eff_h = H_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_r;
    end
    if (channel_count_r == '0) begin
      eff_ch = CFG_CHAN_W'(1);
    end else if (channel_count_r > CFG_CHAN_W'(MAX_CHANNELS)) begin
      eff_ch = CFG_CHAN_W'(MAX_CHANNELS);
    end else begin
      eff_ch = channel_count_r;
    end
  end

  // --------------------------------------------------------------------
  // Register write decode
  assign cfg_ready = 1'b1;
  always_comb begin
    image_width_nxt   = image_width_r;
    image_height_nxt  = image_height_r;
    channel_count_nxt = channel_count_r;
    cfg_hit           = 1'b0;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width_nxt = cfg_data[CFG_WIDTH_W-1:0];
          cfg_hit         = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height_nxt = cfg_data[CFG_HEIGHT_W-1:0];
          cfg_hit          = 1'b1;
        end
        CFG_CHANNEL_COUNT: begin
          channel_count_nxt = cfg_data[CFG_CHAN_W-1:0];
          cfg_hit           = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------
  // Input decode: item class, window position, line store addresses
  assign in_ch[0] = in_data.in_chan0;
  assign in_ch[1] = in_data.in_chan1;
  assign in_ch[2] = in_data.in_chan2;
  assign in_ch[3] = in_data.in_chan3;

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_pack
    assign cur_px[k*CH_W +: CH_W] = in_ch[k];
  end

  assign in_acc    = in_valid && !in_stall;
  assign is_drain  = (in_data.kind == KIND_DRAIN);
  assign drain_act = is_drain && (pending_r != '0);
  assign pix_act   = !is_drain && (pending_r == '0);

  always_comb begin
    produce = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_r != '0);
    // center of the window that completes with this pixel
    if (col_r != '0) begin
      orow = row_r - ROW_W'(1);
      ocol = WW'(col_r) - WW'(1);
    end else begin
      orow = row_r - ROW_W'(2);
      ocol = eff_w - WW'(1);
    end
    interior = (orow != '0) && (H_W'(orow) + H_W'(2) <= eff_h) &&
               (ocol != '0) && ((WW+1)'(ocol) + (WW+1)'(2) <= (WW+1)'(eff_w));
    // drain reads: with eff_w+1 pending, the first pending pixel sits in the upper store
    sel_upper = (pending_r == PW'(eff_w) + PW'(1));
    if (is_drain) begin
      up_rd_addr  = AW'(eff_w - WW'(1));
      mid_rd_addr = AW'(PW'(eff_w) - pending_r);
    end else begin
      up_rd_addr  = col_r;
      mid_rd_addr = col_r;
    end
  end

  // Position and pending count
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pending_nxt = pending_r;
    if (cfg_hit) begin
      col_nxt     = '0;
      row_nxt     = '0;
      pending_nxt = '0;
    end else if (in_acc && drain_act) begin
      pending_nxt = pending_r - PW'(1);
    end else if (in_acc && pix_act) begin
      if (WW'(col_r) + WW'(1) >= eff_w) begin
        col_nxt = '0;
        if (H_W'(row_r) + H_W'(1) >= eff_h) begin
          row_nxt     = '0;
          pending_nxt = (eff_h == H_W'(1)) ? PW'(eff_w) : PW'(eff_w) + PW'(1);
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------
  // Line stores
  bb_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .PXW   (PXW)
  ) u_line_buf (
    .clk         (clk),
    .rd_en       (in_acc),
    .up_rd_addr  (up_rd_addr),
    .mid_rd_addr (mid_rd_addr),
    .wr_en       (s1_go && s1_pix_r),
    .wr_addr     (s1_col_r),
    .up_wdata    (mid_rd),
    .mid_wdata   (s1_cur_r),
    .up_rd_data  (up_rd),
    .mid_rd_data (mid_rd)
  );

  // --------------------------------------------------------------------
  // Working stage flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign out_load = s1_go && s1_emit_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = drain_act || pix_act;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Window cells: two held columns, then the newest column
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      cells[i] = wc_r[i];
    end
    cells[6] = up_rd;
    cells[7] = mid_rd;
    cells[8] = s1_cur_r;
  end

  // Per-channel nine-cell mean
  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_mean
    logic [SUM_W-1:0] sum;
    always_comb begin
      sum = '0;
      for (int i = 0; i < CELLS; i++) begin
        sum = sum + SUM_W'(cells[i][k*CH_W +: CH_W]);
      end
    end
    assign mean_px[k*CH_W +: CH_W] = div9(sum);
  end

  // Result select
  always_comb begin
    if (!s1_pix_r) begin
      res_px = s1_sel_upper_r ? up_rd : mid_rd;
    end else if (s1_interior_r) begin
      res_px = mean_px;
    end else begin
      res_px = wc_r[4];
    end
  end

  // Channels beyond the configured count read as zero
  for (genvar k = 0; k < NUM_CH; k++) begin : g_och
    if (k < MAX_CHANNELS) begin : g_live
      assign och[k] = (CFG_CHAN_W'(k) < eff_ch) ? res_px[k*CH_W +: CH_W] : '0;
    end else begin : g_zero
      assign och[k] = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= RST_WIDTH;
      image_height_r  <= RST_HEIGHT;
      channel_count_r <= RST_CHAN;
      col_r           <= '0;
      row_r           <= '0;
      pending_r       <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      image_width_r   <= image_width_nxt;
      image_height_r  <= image_height_nxt;
      channel_count_r <= channel_count_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      pending_r       <= pending_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Working stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r       <= !is_drain;
      s1_emit_r      <= is_drain || produce;
      s1_interior_r  <= interior;
      s1_sel_upper_r <= sel_upper;
      s1_last_r      <= (pending_r == PW'(1));
      s1_col_r       <= col_r;
      s1_cur_r       <= cur_px;
    end
  end

  // Window column shift
  always_ff @(posedge clk) begin
    if (s1_go && s1_pix_r) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= up_rd;
      wc_r[4] <= mid_rd;
      wc_r[5] <= s1_cur_r;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_chan0  <= och[0];
      out_data_r.out_chan1  <= och[1];
      out_data_r.out_chan2  <= och[2];
      out_data_r.out_chan3  <= och[3];
      out_data_r.frame_last <= !s1_pix_r && s1_last_r;
    end
  end

`ifndef SYNTH
  // Draining only happens with the position parked at the frame origin
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != '0 |-> (col_r == '0 && row_r == '0))
    else $error("pending pixels with nonzero position");

  // Column stays inside the configured width
  assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < eff_w)
    else $error("column position beyond image width");

  // Row stays inside the configured height
  assert property (@(posedge clk) disable iff (!rst_n)
    H_W'(row_r) < eff_h)
    else $error("row position beyond image height");

  // Input backs up only behind a stalled result with another one queued
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_emit_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
module testbench import bb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH  = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYC  = 8;     // covers the two-stage pipe with margin
  localparam int HOLD_CYC    = 200;   // long receiver hold-off
  localparam int HOLD_QUEUE  = 16;    // items queued before a hold-off may start
  localparam int RAND_ITEMS  = 750;
  localparam int EDGE_ITEMS  = 1040;  // one clamped full-width row and a bit more

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_blur_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stimulus and expected-result stores
  in_item_t  feed_q[$];
  out_item_t blurred_q[$];

  int  bad_count  = 0;
  int  rcv_count  = 0;
  int  cyc_count  = 0;
  int  rand_count = 0;
  int  hold_left  = 0;
  int  next_hold  = 300;
  bit  in_xfer    = 1'b0;

  // Shadow of the filter state
  logic [31:0]             up_line  [0:LINE_DEPTH-1];
  logic [31:0]             mid_line [0:LINE_DEPTH-1];
  logic [31:0]             win      [0:5];   // [0..2] older column, [3..5] newer
  int unsigned             col_pos, row_pos, pend;
  logic [CFG_WIDTH_W-1:0]  reg_w;
  logic [CFG_HEIGHT_W-1:0] reg_h;
  logic [CFG_CHAN_W-1:0]   reg_ch;

  // Registers as the block uses them, clamped to their legal ranges
  function automatic int unsigned eff_w();
    if (reg_w < 1) return 1;
    if (reg_w > LINE_DEPTH) return LINE_DEPTH;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_h < 1) return 1;
    if (reg_h > MAX_HEIGHT) return MAX_HEIGHT;
    return reg_h;
  endfunction

  function automatic int unsigned eff_ch();
    if (reg_ch < 1) return 1;
    if (reg_ch > NUM_CH) return NUM_CH;
    return reg_ch;
  endfunction

  // Per-channel truncated mean of nine packed pixels
  function automatic logic [31:0] mean9(input logic [8:0][31:0] cells);
    logic [31:0] res;
    int unsigned sum;
    res = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sum = 0;
      for (int i = 0; i < CELLS; i++) sum += cells[i][8*k +: 8];
      sum = sum / 9;
      if (sum > 255) sum = 255;
      res[8*k +: 8] = sum[7:0];
    end
    return res;
  endfunction

  // Output pixel with channels beyond the configured count zeroed
  function automatic out_item_t shape_out(input logic [31:0] px, input logic last);
    out_item_t o;
    int unsigned n;
    n = eff_ch();
    o.out_chan0  = px[7:0];
    o.out_chan1  = (n > 1) ? px[15:8]  : '0;
    o.out_chan2  = (n > 2) ? px[23:16] : '0;
    o.out_chan3  = (n > 3) ? px[31:24] : '0;
    o.frame_last = last;
    return o;
  endfunction

  // One item through the filter; returns 1 when it yields a pixel
  function automatic bit blur_step(input in_item_t it, output out_item_t res);
    int unsigned     w, h, c, r, orow, ocol;
    logic [31:0]     up, mid, cur, px;
    logic [8:0][31:0] cells;
    bit              produce;
    w = eff_w();
    h = eff_h();
    c = col_pos;
    r = row_pos;
    res = '0;

    // drain: hand out one pending pixel
    if (it.kind == KIND_DRAIN) begin
      if (pend == 0) return 1'b0;
      if (pend == w + 1) px = up_line[w - 1];
      else px = mid_line[w - pend];
      pend--;
      res = shape_out(px, pend == 0);
      return 1'b1;
    end

    if (pend != 0) return 1'b0;
    if (c >= w) c = 0;
    if (r >= h) r = 0;

    cur = {it.in_chan3, it.in_chan2, it.in_chan1, it.in_chan0};
    up  = up_line[c];
    mid = mid_line[c];

    // centre pixel of the window one row up and one column back
    produce = (r >= 2) || (r == 1 && c >= 1);
    if (produce) begin
      px = win[4];
      if (c >= 1) begin
        orow = r - 1;
        ocol = c - 1;
      end else begin
        orow = r - 2;
        ocol = w - 1;
      end
      if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
        cells = {cur, mid, up, win[5], win[4], win[3], win[2], win[1], win[0]};
        px = mean9(cells);
      end
      res = shape_out(px, 1'b0);
    end

    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = cur;
    up_line[c]  = mid;
    mid_line[c] = cur;

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        pend = (h == 1) ? w : w + 1;
      end
    end
    col_pos = c;
    row_pos = r;
    return produce;
  endfunction

  // Register write: applies at once and restarts the frame
  function automatic void apply_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_IMAGE_WIDTH:   reg_w  = val[CFG_WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT:  reg_h  = val[CFG_HEIGHT_W-1:0];
      CFG_CHANNEL_COUNT: reg_ch = val[CFG_CHAN_W-1:0];
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
    pend    = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cyc_count, msg);
    bad_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Idling off during a calm stretch at the end of each period
  function automatic bit take_break();
    return ((cyc_count % 4000) < 3200) && ($urandom_range(0, 99) < 10);
  endfunction

  // Item builders
  function automatic in_item_t pixel_of(input logic [7:0] c0, c1, c2, c3);
    in_item_t it;
    it.kind     = KIND_PIXEL;
    it.in_chan0 = c0;
    it.in_chan1 = c1;
    it.in_chan2 = c2;
    it.in_chan3 = c3;
    return it;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t rand_pixel();
    return pixel_of(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic in_item_t drain_item();
    in_item_t it;
    it = rand_pixel();
    it.kind = KIND_DRAIN;
    return it;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Input transfer: predict at the edge that takes the item
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (blur_step(in_data, want)) blurred_q.push_back(want);
      in_xfer = 1'b1;
    end
  end

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      in_xfer = 1'b0;
      if (feed_q.size() != 0 && !take_break()) begin
        in_valid <= 1'b1;
        in_data  <= feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a periodic long hold-off, started only
  // while the sender still has plenty queued so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rcv_count >= next_hold && feed_q.size() >= HOLD_QUEUE) begin
      hold_left = HOLD_CYC;
      next_hold += 2000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= take_break();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      rcv_count++;
      if (blurred_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = blurred_q.pop_front();
        check_field("out_chan0", out_data.out_chan0, want.out_chan0);
        check_field("out_chan1", out_data.out_chan1, want.out_chan1);
        check_field("out_chan2", out_data.out_chan2, want.out_chan2);
        check_field("out_chan3", out_data.out_chan3, want.out_chan3);
        check_field("frame_last", 8'(out_data.frame_last), 8'(want.frame_last));
      end
    end
  end

  // Wait for all queued items and results, then let the pipe empty
  task automatic settle();
    while (feed_q.size() != 0 || in_valid || blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] w, h, ch);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_CHANNEL_COUNT, ch);
    end else begin
      write_reg(CFG_CHANNEL_COUNT, ch);
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_IMAGE_WIDTH, w);
    end
  endtask

  // One frame: pixels, then drains; noisy frames add ignored items
  // and are sometimes cut short to exercise the abort on a write
  task automatic run_frame(input bit noisy, output bit broken);
    int unsigned w, h, n, cut, drains;
    w = eff_w();
    h = eff_h();
    n = w * h;
    cut = n;
    broken = 1'b0;
    if (noisy && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, n - 1);
      broken = 1'b1;
    end
    for (int unsigned k = 0; k < cut; k++) begin
      if (noisy && $urandom_range(0, 32) == 0) feed_q.push_back(drain_item());
      feed_q.push_back(rand_pixel());
      rand_count++;
    end
    if (broken) return;
    // pixel while the drain is pending: dropped
    if (noisy && $urandom_range(0, 3) == 0) feed_q.push_back(rand_pixel());
    drains = (h == 1) ? w : w + 1;
    if (noisy && $urandom_range(0, 9) == 0) begin
      drains = $urandom_range(0, drains - 1);
      broken = 1'b1;
    end
    for (int unsigned k = 0; k < drains; k++) begin
      feed_q.push_back(drain_item());
      rand_count++;
    end
    // drain with nothing pending: dropped
    if (!broken && noisy && $urandom_range(0, 3) == 0) feed_q.push_back(drain_item());
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, h, ch,
                           input bit must_write, input bit noisy, output bit broken);
    int nf;
    broken = 1'b0;
    if (must_write || $urandom_range(0, 3) != 0) write_all(w, h, ch);
    nf = $urandom_range(1, 2);
    for (int f = 0; f < nf && !broken; f++) run_frame(noisy, broken);
    settle();
  endtask

  initial begin
    bit                    broken;
    logic [CFG_DATA_W-1:0] w, h, ch;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      up_line[i]  = '0;
      mid_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    pend    = 0;
    reg_w   = RST_WIDTH;
    reg_h   = RST_HEIGHT;
    reg_ch  = RST_CHAN;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: drain with nothing pending, two pixels at reset settings
    feed_q.push_back(drain_item());
    feed_q.push_back(pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    feed_q.push_back(pixel_of(8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // Directed 3x3 frame, all channels; one interior pixel
    write_all(13'd3, 13'd3, 13'd4);
    for (int p = 0; p < 9; p++)
      feed_q.push_back(pixel_of(8'hFF, 8'h00, (p % 2 == 0) ? 8'hFF : 8'h00, 8'(p * 31)));
    feed_q.push_back(pixel_of(8'h55, 8'hAA, 8'h55, 8'hAA));   // dropped, drain pending
    for (int k = 0; k < 5; k++) feed_q.push_back(drain_item()); // last one dropped
    settle();

    // Directed 1x1 frame, channel count below range
    write_all(13'd1, 13'd1, 13'd0);
    feed_q.push_back(pixel_of(8'hA5, 8'h5A, 8'hC3, 8'h3C));
    feed_q.push_back(drain_item());
    settle();

    // Random phases, mostly small frames
    broken = 1'b1;
    while (rand_count < RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          w = $urandom_range(0, 3);
          h = $urandom_range(0, 3);
        end
        2: begin
          w = $urandom_range(20, 64);
          h = $urandom_range(2, 4);
        end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 8);
        end
      endcase
      ch = $urandom_range(0, 7);
      run_phase(w, h, ch, broken, 1'b1, broken);
    end

    // Extremes: width and height above range, so the line is the widest
    // one; the frame runs past the end of its first row and stops there
    write_all(13'd2047, 13'd8191, 13'd5);
    for (int k = 0; k < EDGE_ITEMS; k++) feed_q.push_back(rand_pixel());
    settle();

    if (blurred_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", blurred_q.size()));
    if (bad_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bb_pkg.sv
design/bb_line_buf.sv
design/box_blur_3x3.sv
tb/sv/testbench.sv
